[hdl/flr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flr_pkg
// Shared types and constants for the float literal recognizer.
// ----------------------------------------------------------------------------
package flr_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned PhaseW = 5;

  // Parse phase. INFk / NANk: k letters of the word matched so far.
  typedef enum logic [PhaseW-1:0] {
    PH_START    = 5'd0,
    PH_SIGN     = 5'd1,
    PH_INT      = 5'd2,
    PH_DOT0     = 5'd3,
    PH_FRAC     = 5'd4,
    PH_EXP      = 5'd5,
    PH_EXP_SIGN = 5'd6,
    PH_EXP_DIG  = 5'd7,
    PH_INF1     = 5'd8,
    PH_INF2     = 5'd9,
    PH_INF3     = 5'd10,
    PH_INF4     = 5'd11,
    PH_INF5     = 5'd12,
    PH_INF6     = 5'd13,
    PH_INF7     = 5'd14,
    PH_INF8     = 5'd15,
    PH_NAN1     = 5'd16,
    PH_NAN2     = 5'd17,
    PH_NAN3     = 5'd18,
    PH_REJECT   = 5'd19
  } phase_t;

  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] Ch0     = 8'h30;
  localparam logic [CharW-1:0] Ch9     = 8'h39;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
  localparam logic [CharW-1:0] CaseBit = 8'h20;
  localparam logic [CharW-1:0] ChLoA   = 8'h61;
  localparam logic [CharW-1:0] ChLoE   = 8'h65;
  localparam logic [CharW-1:0] ChLoF   = 8'h66;
  localparam logic [CharW-1:0] ChLoI   = 8'h69;
  localparam logic [CharW-1:0] ChLoN   = 8'h6E;
  localparam logic [CharW-1:0] ChLoT   = 8'h74;
  localparam logic [CharW-1:0] ChLoY   = 8'h79;

  // Byte classification handed from the classifier to the step logic.
  typedef struct packed {
    logic digit;
    logic sign;
    logic dot;
    logic let_a;
    logic let_e;
    logic let_f;
    logic let_i;
    logic let_n;
    logic let_t;
    logic let_y;
  } char_class_t;

endpackage

[hdl/float_literal_recognizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_literal_recognizer
// Byte-serial check of a strict decimal float literal (incl. inf/infinity/nan).
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_stall): one byte per transfer, char_code plus
//   is_last marking the final byte of a string. Strings run back to back.
//   Result channel (result_valid/result_stall): one transfer per string,
//   accepted = 1 when the whole string is a valid literal.
//   Throughput: one byte per cycle while item_stall is low; the parse phase
//   register is the only loop and its update is one short classify-and-step
//   path. Verdict path: the last byte passes the input register, then the
//   result register, from which the verdict is shown.
//   Stall: non-final bytes never wait on the result side. A final byte waits
//   in the input register only while an undelivered verdict sits in the
//   result register and result_stall is high; item_stall then goes high.
//   Reset (rst, synchronous): both registers empty, phase back to start of
//   string. Verdicts held at reset are dropped.
// ----------------------------------------------------------------------------
module float_literal_recognizer
  import flr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  logic [CharW-1:0] char_code,
  input  logic             is_last,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             accepted
);

  // input register
  logic             s1_valid;
  logic [CharW-1:0] s1_char;
  logic             s1_last;

  phase_t      phase;
  phase_t      phase_next;
  char_class_t cls;
  logic        accepting;

  logic s1_adv;
  logic item_take;
  logic result_take;

  flr_char_class u_class (
    .char_code (s1_char),
    .cls       (cls)
  );

  flr_step u_step (
    .phase      (phase),
    .cls        (cls),
    .phase_next (phase_next),
    .accepting  (accepting)
  );

  assign result_take = result_valid && !result_stall;
  // a final byte needs a free (or freeing) result slot
  assign s1_adv      = s1_valid && (!s1_last || !result_valid || !result_stall);
  assign item_stall  = s1_valid && !s1_adv;
  assign item_take   = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      phase        <= PH_START;
      result_valid <= 1'b0;
    end else begin
      if (item_take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      // end of string returns to start
      if (s1_adv) begin
        phase <= s1_last ? PH_START : phase_next;
      end

      if (s1_adv && s1_last) begin
        result_valid <= 1'b1;
      end else if (result_take) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_char <= char_code;
      s1_last <= is_last;
    end
    if (s1_adv && s1_last) begin
      accepted <= accepting;
    end
  end

endmodule

[hdl/flr_char_class.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flr_char_class
// Classifies one byte: digit, sign, dot and case-folded letter matches.
// ----------------------------------------------------------------------------
module flr_char_class
  import flr_pkg::*;
(
  input  logic [CharW-1:0] char_code,
  output char_class_t      cls
);

  logic [CharW-1:0] lc;

  // only ASCII A..Z fold
  assign lc = (char_code >= ChUpA && char_code <= ChUpZ) ? (char_code | CaseBit)
                                                         : char_code;

  always_comb begin
    cls.digit = (char_code >= Ch0) && (char_code <= Ch9);
    cls.sign  = (char_code == ChPlus) || (char_code == ChMinus);
    cls.dot   = (char_code == ChDot);
    cls.let_a = (lc == ChLoA);
    cls.let_e = (lc == ChLoE);
    cls.let_f = (lc == ChLoF);
    cls.let_i = (lc == ChLoI);
    cls.let_n = (lc == ChLoN);
    cls.let_t = (lc == ChLoT);
    cls.let_y = (lc == ChLoY);
  end

endmodule

[hdl/flr_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flr_step
// Next parse phase for one classified byte, and the accepting flag of it.
// ----------------------------------------------------------------------------
module flr_step
  import flr_pkg::*;
(
  input  phase_t      phase,
  input  char_class_t cls,
  output phase_t      phase_next,
  output logic        accepting
);

  always_comb begin
    phase_next = PH_REJECT;
    unique case (phase)
      PH_START, PH_SIGN: begin
        priority if (phase == PH_START && cls.sign) phase_next = PH_SIGN;
        else if (cls.digit) phase_next = PH_INT;
        else if (cls.dot)   phase_next = PH_DOT0;
        else if (cls.let_i) phase_next = PH_INF1;
        else if (cls.let_n) phase_next = PH_NAN1;
        else                phase_next = PH_REJECT;
      end
      PH_INT: begin
        priority if (cls.digit) phase_next = PH_INT;
        else if (cls.dot)   phase_next = PH_FRAC;
        else if (cls.let_e) phase_next = PH_EXP;
        else                phase_next = PH_REJECT;
      end
      PH_DOT0:     phase_next = cls.digit ? PH_FRAC : PH_REJECT;
      PH_FRAC: begin
        priority if (cls.digit) phase_next = PH_FRAC;
        else if (cls.let_e) phase_next = PH_EXP;
        else                phase_next = PH_REJECT;
      end
      PH_EXP: begin
        priority if (cls.sign) phase_next = PH_EXP_SIGN;
        else if (cls.digit) phase_next = PH_EXP_DIG;
        else                phase_next = PH_REJECT;
      end
      PH_EXP_SIGN, PH_EXP_DIG: phase_next = cls.digit ? PH_EXP_DIG : PH_REJECT;
      // "infinity", letter by letter
      PH_INF1: phase_next = cls.let_n ? PH_INF2 : PH_REJECT;
      PH_INF2: phase_next = cls.let_f ? PH_INF3 : PH_REJECT;
      PH_INF3: phase_next = cls.let_i ? PH_INF4 : PH_REJECT;
      PH_INF4: phase_next = cls.let_n ? PH_INF5 : PH_REJECT;
      PH_INF5: phase_next = cls.let_i ? PH_INF6 : PH_REJECT;
      PH_INF6: phase_next = cls.let_t ? PH_INF7 : PH_REJECT;
      PH_INF7: phase_next = cls.let_y ? PH_INF8 : PH_REJECT;
      // "nan"
      PH_NAN1: phase_next = cls.let_a ? PH_NAN2 : PH_REJECT;
      PH_NAN2: phase_next = cls.let_n ? PH_NAN3 : PH_REJECT;
      // infinity and nan take no more bytes; reject and unused codes stick
      default: phase_next = PH_REJECT;
    endcase
  end

  assign accepting = (phase_next == PH_INT)     || (phase_next == PH_FRAC) ||
                     (phase_next == PH_EXP_DIG) || (phase_next == PH_INF3) ||
                     (phase_next == PH_INF8)    || (phase_next == PH_NAN3);

endmodule

[hdl/flr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flr_checker
// Port-level checks for the float literal recognizer, bound to the top level.
// ----------------------------------------------------------------------------
module flr_checker
  import flr_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input logic [CharW-1:0] char_code,
  input logic             is_last,
  input logic             result_valid,
  input logic             result_stall,
  input logic             accepted
);

  // held verdict stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(accepted))
    else $error("verdict dropped or changed while stalled");

  // input backs up only behind a stalled verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("item stall without a blocked verdict");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("verdict present after reset");

  // at most one byte waits, so a stall lasts only while the verdict is blocked
  a_stall_release: assert property (@(posedge clk) disable iff (rst)
    item_stall && !result_stall |=> !item_stall)
    else $error("item stall outlived the blocked verdict");

  // a stalled byte is held by the sender
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(char_code) && $stable(is_last))
    else $error("item payload changed while stalled");

endmodule

bind float_literal_recognizer flr_checker u_flr_checker (.*);
